[src/log_line_severity_classifier_core_macros.svh]
// ============================================================================
// Assertion macros for the log line severity classifier
// Two property shapes, both clocked on clk_i and held off during reset.
// ============================================================================
`ifndef LOG_LINE_SEVERITY_CLASSIFIER_CORE_MACROS_SVH
`define LOG_LINE_SEVERITY_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication
`define LLSC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("llsc assertion failed");

// Next-cycle implication
`define LLSC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("llsc assertion failed");

`endif

[src/llsc_pkg.sv]
// ============================================================================
// llsc_pkg
// Types, keyword tables and byte-compare helpers for the severity classifier.
// ============================================================================
package llsc_pkg;

  // Byte history depth (index 0 is the newest byte)
  localparam int unsigned WIN = 10;
  localparam int unsigned NUM_WORDS = 23;
  localparam int unsigned NUM_FOLD = 5;
  localparam int unsigned NUM_EXACT = 3;

  typedef logic [WIN-1:0][7:0] win_t;
  typedef logic [WIN-1:0][7:0] pat_t;   // pattern, last char in byte 0
  typedef logic [3:0]          cnt_t;

  typedef enum logic [1:0] {
    CLS_NORMAL  = 2'd0,
    CLS_ERROR   = 2'd1,
    CLS_WARNING = 2'd2,
    CLS_INFO    = 2'd3
  } line_class_e;

  // Sticky keyword hits
  typedef struct packed {
    logic err;
    logic warn;
    logic info;
  } hits_t;

  // Whole-word keywords, exact case
  localparam pat_t WORD_PAT [NUM_WORDS] = '{
    80'("error"), 80'("Error"), 80'("ERROR"), 80'("FAILED"), 80'("FAIL"),
    80'("fatal"), 80'("Fatal"), 80'("FATAL"), 80'("panic"), 80'("PANIC"),
    80'("warning"), 80'("Warning"), 80'("WARNING"), 80'("WARN"), 80'("warn"),
    80'("note"), 80'("Note"), 80'("NOTE"), 80'("info"), 80'("Info"),
    80'("INFO"), 80'("hint"), 80'("Hint")
  };
  localparam cnt_t WORD_LEN [NUM_WORDS] = '{
    4'd5, 4'd5, 4'd5, 4'd6, 4'd4,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd7, 4'd7, 4'd7, 4'd4, 4'd4,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd4, 4'd4, 4'd4
  };
  localparam line_class_e WORD_CLS [NUM_WORDS] = '{
    CLS_ERROR, CLS_ERROR, CLS_ERROR, CLS_ERROR, CLS_ERROR,
    CLS_ERROR, CLS_ERROR, CLS_ERROR, CLS_ERROR, CLS_ERROR,
    CLS_WARNING, CLS_WARNING, CLS_WARNING, CLS_WARNING, CLS_WARNING,
    CLS_INFO, CLS_INFO, CLS_INFO, CLS_INFO, CLS_INFO,
    CLS_INFO, CLS_INFO, CLS_INFO
  };

  // Case-insensitive substrings
  localparam pat_t FOLD_PAT [NUM_FOLD] = '{
    80'("panicked"), 80'("ERR!"), 80'("Traceback"), 80'("Exception"), 80'("deprecated")
  };
  localparam cnt_t FOLD_LEN [NUM_FOLD] = '{4'd8, 4'd4, 4'd9, 4'd9, 4'd10};
  localparam line_class_e FOLD_CLS [NUM_FOLD] = '{
    CLS_ERROR, CLS_ERROR, CLS_ERROR, CLS_ERROR, CLS_WARNING
  };

  // Exact substrings, all errors
  localparam pat_t EXACT_PAT [NUM_EXACT] = '{
    80'("error[E"), 80'("error C"), 80'(": error:")
  };
  localparam cnt_t EXACT_LEN [NUM_EXACT] = '{4'd7, 4'd7, 4'd8};

  // ASCII upper to lower
  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    fold_byte = (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // Pattern of length len ends at window index off
  function automatic logic ends_at(input win_t win, input cnt_t cnt, input cnt_t off,
                                   input pat_t pat, input cnt_t len, input logic ci);
    logic       ok;
    logic [4:0] span;
    logic [4:0] pos;
    logic [7:0] w;
    logic [7:0] k;
    span = {1'b0, off} + {1'b0, len};
    ok   = (span <= 5'(WIN)) && ({1'b0, cnt} >= span);
    for (int j = 0; j < WIN; j++) begin
      pos = {1'b0, off} + 5'(j);
      if ((5'(j) < {1'b0, len}) && (pos < 5'(WIN))) begin
        w = win[pos[3:0]];
        k = pat[j];
        if (ci) begin
          w = fold_byte(w);
          k = fold_byte(k);
        end
        if (w != k) begin
          ok = 1'b0;
        end
      end
    end
    ends_at = ok;
  endfunction

endpackage

[src/log_line_severity_classifier_core.sv]
// ============================================================================
// log_line_severity_classifier_core
// Classifies a text line, one byte per transaction, as normal, error, warning
// or info; one result per line terminator.
// ============================================================================
//
//   Channel   Dir   Payload                              Result
//   s_axis    in    tdata[7:0] text byte, tlast = EOL    none per byte
//   m_axis    out   tdata[1:0] line class                one per EOL
//
// One transaction per cycle sustained while m_axis takes results: input register,
// one level of parallel window compares, then state and result registers. An
// accepted terminator passes the input register, then the result register.
// Reset clears the window, byte count, hit flags and both pipeline valids.
// A stalled m_axis holds a terminator in the input register and the bytes behind it.
//
`include "log_line_severity_classifier_core_macros.svh"

module log_line_severity_classifier_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,   // end_of_line
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [1:0] line_class, [7:2] zero
);

  typedef enum logic [3:0] {
    UL_LEAD  = 4'b0001,
    UL_MARK  = 4'b0010,
    UL_TRAIL = 4'b0100,
    UL_NONE  = 4'b1000
  } ul_phase_e;

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_eol_q;
  logic       s1_adv;

  // Line state
  llsc_pkg::win_t  win_q, win_d;
  llsc_pkg::cnt_t  cnt_q, cnt_d;
  llsc_pkg::hits_t flags_q, flags_d;
  ul_phase_e       phase_q, phase_d;

  // Result register
  logic                  out_valid_q, out_valid_d;
  llsc_pkg::line_class_e out_class_q, out_class_d;

  llsc_pkg::win_t  win_new;
  llsc_pkg::cnt_t  cnt_new;
  llsc_pkg::hits_t sub_hits;
  llsc_pkg::hits_t word_hits;
  logic            boundary;
  logic            ul_err;
  llsc_pkg::hits_t eol_hits;

  // Handshake: a byte never waits on the output, a terminator waits for room
  assign s1_adv        = s1_valid_q && (!s1_eol_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_class_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_byte_q <= s_axis_tdata;
      s1_eol_q  <= s_axis_tlast;
    end
  end

  // Shifted window; on a terminator the newest slot is a don't-care filler
  assign win_new  = {win_q[llsc_pkg::WIN-2:0], s1_byte_q};
  assign cnt_new  = (cnt_q == 4'hF) ? cnt_q : cnt_q + 4'd1;
  assign boundary = (s1_byte_q == 8'h20) || (s1_byte_q == 8'h3A) ||
                    (s1_byte_q == 8'h5D) || (s1_byte_q == 8'h29);

  llsc_match u_match (
    .win_i  (win_new),
    .cnt_i  (cnt_new),
    .sub_o  (sub_hits),
    .word_o (word_hits)
  );

  // Underline tracker
  always_comb begin
    unique case (phase_q)
      UL_LEAD:  phase_d = (s1_byte_q == 8'h20) ? UL_LEAD :
                          (s1_byte_q == 8'h5E) ? UL_MARK : UL_NONE;
      UL_MARK:  phase_d = ((s1_byte_q == 8'h5E) || (s1_byte_q == 8'h7E)) ? UL_MARK :
                          (s1_byte_q == 8'h20) ? UL_TRAIL : UL_NONE;
      UL_TRAIL: phase_d = (s1_byte_q == 8'h20) ? UL_TRAIL : UL_NONE;
      default:  phase_d = UL_NONE;
    endcase
  end

  // Terminator: fold in the word ending at line end and the underline rule
  assign ul_err        = ((phase_q == UL_MARK) || (phase_q == UL_TRAIL)) && (cnt_q >= 4'd2);
  assign eol_hits.err  = flags_q.err | word_hits.err | ul_err;
  assign eol_hits.warn = flags_q.warn | word_hits.warn;
  assign eol_hits.info = flags_q.info | word_hits.info;

  always_comb begin
    priority if (cnt_q == 4'd0) begin
      out_class_d = llsc_pkg::CLS_NORMAL;
    end else if (eol_hits.err) begin
      out_class_d = llsc_pkg::CLS_ERROR;
    end else if (eol_hits.warn) begin
      out_class_d = llsc_pkg::CLS_WARNING;
    end else if (eol_hits.info) begin
      out_class_d = llsc_pkg::CLS_INFO;
    end else begin
      out_class_d = llsc_pkg::CLS_NORMAL;
    end
  end

  // Sticky hits for a byte
  always_comb begin
    flags_d.err  = flags_q.err | sub_hits.err | (boundary & word_hits.err);
    flags_d.warn = flags_q.warn | sub_hits.warn | (boundary & word_hits.warn);
    flags_d.info = flags_q.info | sub_hits.info | (boundary & word_hits.info);
    win_d        = win_new;
    cnt_d        = cnt_new;
  end

  // Line state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      cnt_q   <= '0;
      flags_q <= '0;
      phase_q <= UL_LEAD;
    end else if (s1_adv) begin
      if (s1_eol_q) begin
        win_q   <= '0;
        cnt_q   <= '0;
        flags_q <= '0;
        phase_q <= UL_LEAD;
      end else begin
        win_q   <= win_d;
        cnt_q   <= cnt_d;
        flags_q <= flags_d;
        phase_q <= phase_d;
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_eol_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_eol_q) begin
      out_class_q <= out_class_d;
    end
  end

  // Checks
  `LLSC_ASSERT_NXT(a_eol_clears, s1_adv && s1_eol_q, (cnt_q == 4'd0) && (flags_q == '0))
  `LLSC_ASSERT_NXT(a_empty_normal, s1_adv && s1_eol_q && (cnt_q == 4'd0),
                   out_valid_q && (out_class_q == llsc_pkg::CLS_NORMAL))
  `LLSC_ASSERT_IMP(a_fresh_line_lead, cnt_q == 4'd0, phase_q == UL_LEAD)
  `LLSC_ASSERT_IMP(a_no_stall_when_empty, s1_valid_q && !out_valid_q, s1_adv)

endmodule

[src/llsc_match.sv]
// ============================================================================
// llsc_match
// Parallel keyword compare against the shifted byte window.
// ============================================================================
module llsc_match (
  input  llsc_pkg::win_t  win_i,     // window after the current byte, index 0 newest
  input  llsc_pkg::cnt_t  cnt_i,     // bytes seen including the current one
  output llsc_pkg::hits_t sub_o,     // substring hits ending at the newest byte
  output llsc_pkg::hits_t word_o     // whole-word hits ending one byte back
);

  logic [llsc_pkg::NUM_WORDS-1:0] word_hit;
  logic [llsc_pkg::NUM_FOLD-1:0]  fold_hit;
  logic [llsc_pkg::NUM_EXACT-1:0] exact_hit;

  // Whole words: end at index 1, left boundary at index 1 + len
  for (genvar k = 0; k < llsc_pkg::NUM_WORDS; k++) begin : g_word
    localparam llsc_pkg::cnt_t Before = llsc_pkg::WORD_LEN[k] + 4'd1;
    assign word_hit[k] =
      llsc_pkg::ends_at(win_i, cnt_i, 4'd1, llsc_pkg::WORD_PAT[k],
                        llsc_pkg::WORD_LEN[k], 1'b0) &&
      ((cnt_i <= Before) || !llsc_pkg::is_alnum(win_i[Before]));
  end

  // Case-folded substrings
  for (genvar k = 0; k < llsc_pkg::NUM_FOLD; k++) begin : g_fold
    assign fold_hit[k] = llsc_pkg::ends_at(win_i, cnt_i, 4'd0, llsc_pkg::FOLD_PAT[k],
                                           llsc_pkg::FOLD_LEN[k], 1'b1);
  end

  // Exact compiler substrings
  for (genvar k = 0; k < llsc_pkg::NUM_EXACT; k++) begin : g_exact
    assign exact_hit[k] = llsc_pkg::ends_at(win_i, cnt_i, 4'd0, llsc_pkg::EXACT_PAT[k],
                                            llsc_pkg::EXACT_LEN[k], 1'b0);
  end

  // Merge hits by class
  always_comb begin
    word_o = '0;
    sub_o  = '0;
    for (int k = 0; k < llsc_pkg::NUM_WORDS; k++) begin
      if (word_hit[k]) begin
        unique case (llsc_pkg::WORD_CLS[k])
          llsc_pkg::CLS_ERROR:   word_o.err  = 1'b1;
          llsc_pkg::CLS_WARNING: word_o.warn = 1'b1;
          default:               word_o.info = 1'b1;
        endcase
      end
    end
    for (int k = 0; k < llsc_pkg::NUM_FOLD; k++) begin
      if (fold_hit[k]) begin
        if (llsc_pkg::FOLD_CLS[k] == llsc_pkg::CLS_ERROR) begin
          sub_o.err = 1'b1;
        end else begin
          sub_o.warn = 1'b1;
        end
      end
    end
    if (|exact_hit) begin
      sub_o.err = 1'b1;
    end
  end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for log_line_severity_classifier_core
// Lines of text are streamed in one byte per transaction, each closed by a
// terminator. A line-level model inside the bench predicts the class of every
// line, and each class on the output stream is checked in order against it.
// Directed lines cover keywords, boundaries, underlines and odd bytes; random
// lines follow, mostly keyword sentences with random surroundings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HISTORY_DEPTH  = 10;
  localparam int RANDOM_ITEMS   = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  // Underline tracker states
  typedef enum logic [1:0] {
    UL_LEAD  = 2'd0,
    UL_MARKS = 2'd1,
    UL_TRAIL = 2'd2,
    UL_NONE  = 2'd3
  } ul_phase_e;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  // Line model state
  logic [7:0]  recent [HISTORY_DEPTH];
  logic [3:0]  seen_count;
  logic        hit_err;
  logic        hit_warn;
  logic        hit_info;
  ul_phase_e   ul_phase;

  llsc_pkg::line_class_e pending_classes [$];
  logic [7:0]  line_bytes [$];
  int          mismatch_count = 0;
  int          items_sent     = 0;
  int          stall_cycles   = 0;
  bit          no_gaps        = 1'b0;

  log_line_severity_classifier_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Keyword tables
  // --------------------------------------------------------------------------
  function automatic string word_text(input int idx);
    case (idx)
      0:  return "error";
      1:  return "Error";
      2:  return "ERROR";
      3:  return "FAILED";
      4:  return "FAIL";
      5:  return "fatal";
      6:  return "Fatal";
      7:  return "FATAL";
      8:  return "panic";
      9:  return "PANIC";
      10: return "warning";
      11: return "Warning";
      12: return "WARNING";
      13: return "WARN";
      14: return "warn";
      15: return "note";
      16: return "Note";
      17: return "NOTE";
      18: return "info";
      19: return "Info";
      20: return "INFO";
      21: return "hint";
      default: return "Hint";
    endcase
  endfunction

  function automatic llsc_pkg::line_class_e word_class(input int idx);
    if (idx < 10) return llsc_pkg::CLS_ERROR;
    if (idx < 15) return llsc_pkg::CLS_WARNING;
    return llsc_pkg::CLS_INFO;
  endfunction

  function automatic string folded_text(input int idx);
    case (idx)
      0: return "panicked";
      1: return "ERR!";
      2: return "Traceback";
      3: return "Exception";
      default: return "deprecated";
    endcase
  endfunction

  function automatic string exact_text(input int idx);
    case (idx)
      0: return "error[E";
      1: return "error C";
      default: return ": error:";
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Line model
  // --------------------------------------------------------------------------
  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit is_word_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Keyword kw ends at history slot off (0 = newest)
  function automatic bit tail_matches(input int off, input string kw, input bit nocase);
    int         n;
    logic [7:0] have;
    logic [7:0] want;
    n = kw.len();
    if (off + n > HISTORY_DEPTH || int'(seen_count) < off + n) return 1'b0;
    for (int i = 0; i < n; i++) begin
      have = recent[off + n - 1 - i];
      want = kw[i];
      if (nocase) begin
        have = lower_ascii(have);
        want = lower_ascii(want);
      end
      if (have != want) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void mark_hit(input llsc_pkg::line_class_e cls);
    case (cls)
      llsc_pkg::CLS_ERROR:   hit_err  = 1'b1;
      llsc_pkg::CLS_WARNING: hit_warn = 1'b1;
      default:               hit_info = 1'b1;
    endcase
  endfunction

  // Whole words ending at slot off; right boundary already established
  function automatic void scan_words(input int off);
    string kw;
    int    left;
    for (int i = 0; i < 23; i++) begin
      kw   = word_text(i);
      left = off + kw.len();
      if (tail_matches(off, kw, 1'b0) &&
          (int'(seen_count) <= left ||
           (left < HISTORY_DEPTH && !is_word_char(recent[left]))))
        mark_hit(word_class(i));
    end
  endfunction

  function automatic void clear_line();
    for (int i = 0; i < HISTORY_DEPTH; i++) recent[i] = 8'h00;
    seen_count = 4'd0;
    hit_err    = 1'b0;
    hit_warn   = 1'b0;
    hit_info   = 1'b0;
    ul_phase   = UL_LEAD;
  endfunction

  // Advance the model by one accepted transaction
  function automatic void absorb_item(input logic [7:0] b, input logic eol);
    llsc_pkg::line_class_e cls;
    if (eol) begin
      cls = llsc_pkg::CLS_NORMAL;
      if (seen_count != 4'd0) begin
        scan_words(0);
        if ((ul_phase == UL_MARKS || ul_phase == UL_TRAIL) && seen_count >= 4'd2)
          hit_err = 1'b1;
        if (hit_err)       cls = llsc_pkg::CLS_ERROR;
        else if (hit_warn) cls = llsc_pkg::CLS_WARNING;
        else if (hit_info) cls = llsc_pkg::CLS_INFO;
      end
      pending_classes.push_back(cls);
      clear_line();
    end else begin
      for (int i = HISTORY_DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = b;
      if (seen_count != 4'd15) seen_count = seen_count + 4'd1;

      case (ul_phase)
        UL_LEAD:  ul_phase = (b == " ") ? UL_LEAD : (b == "^") ? UL_MARKS : UL_NONE;
        UL_MARKS: ul_phase = (b == "^" || b == "~") ? UL_MARKS :
                             (b == " ") ? UL_TRAIL : UL_NONE;
        UL_TRAIL: ul_phase = (b == " ") ? UL_TRAIL : UL_NONE;
        default:  ul_phase = UL_NONE;
      endcase

      for (int i = 0; i < 5; i++)
        if (tail_matches(0, folded_text(i), 1'b1))
          mark_hit((i == 4) ? llsc_pkg::CLS_WARNING : llsc_pkg::CLS_ERROR);
      for (int i = 0; i < 3; i++)
        if (tail_matches(0, exact_text(i), 1'b0)) hit_err = 1'b1;

      if (b == " " || b == ":" || b == "]" || b == ")") scan_words(1);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Predict on accepted input, then check accepted output against the oldest
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_line();
    end else begin
      if (s_axis_tvalid && s_axis_tready) absorb_item(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_classes.size() == 0) begin
          report_mismatch($sformatf("class %0d with no line pending", m_axis_tdata[1:0]));
        end else if (m_axis_tdata[1:0] != pending_classes[0]) begin
          report_mismatch($sformatf("line_class got %0d want %0d",
                                    m_axis_tdata[1:0], pending_classes[0]));
          void'(pending_classes.pop_front());
        end else begin
          void'(pending_classes.pop_front());
        end
      end
    end
  end

  // Output backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 7);
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("log_line_severity_classifier_core verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input logic eol);
    while (!no_gaps && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eol;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Current line bytes, then a terminator carrying junk data
  task automatic send_line();
    foreach (line_bytes[i]) send_item(line_bytes[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    line_bytes.delete();
  endtask

  function automatic void append_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endfunction

  task automatic send_text(input string s);
    append_text(s);
    send_line();
  endtask

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 11))
      0:  return " ";
      1:  return ":";
      2:  return "]";
      3:  return ")";
      4:  return "[";
      5:  return "(";
      6:  return "-";
      7:  return "=";
      8:  return ",";
      9:  return ".";
      10: return 8'h09;
      default: return "/";
    endcase
  endfunction

  function automatic logic [7:0] pick_right_edge();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return ":";
      2: return "]";
      default: return ")";
    endcase
  endfunction

  function automatic logic [7:0] pick_alnum();
    case ($urandom_range(0, 2))
      0: return 8'("a" + $urandom_range(0, 25));
      1: return 8'("A" + $urandom_range(0, 25));
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  // Flip letter case at random
  function automatic string scramble_case(input string s);
    for (int i = 0; i < s.len(); i++)
      if ((lower_ascii(s[i]) >= "a" && lower_ascii(s[i]) <= "z") && $urandom_range(0, 1))
        s[i] = s[i] ^ 8'h20;
    return s;
  endfunction

  // One keyword, near miss or case-shuffled word
  function automatic void add_keyword();
    string kw;
    int    pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      kw = word_text($urandom_range(0, 22));
    end else if (pick < 7) begin
      kw = scramble_case(folded_text($urandom_range(0, 4)));
    end else if (pick == 7) begin
      kw = exact_text($urandom_range(0, 2));
    end else if (pick == 8) begin
      kw = word_text($urandom_range(0, 22));
      if ($urandom_range(0, 1)) kw = kw.substr(0, kw.len() - 2);
      else kw[$urandom_range(0, kw.len() - 1)] = pick_alnum();
    end else begin
      kw = scramble_case(word_text($urandom_range(0, 22)));
    end
    append_text(kw);
  endfunction

  function automatic void add_noise(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) line_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_random_line();
    int mode;
    int r;
    mode = $urandom_range(0, 99);
    if (mode < 60) begin
      // keyword sentence, sometimes behind a long lead-in
      if ($urandom_range(0, 99) < 15)
        repeat ($urandom_range(8, 16))
          line_bytes.push_back($urandom_range(0, 3) == 0 ? 8'h20 : pick_alnum());
      repeat ($urandom_range(1, 2)) begin
        r = $urandom_range(0, 9);
        if (r >= 8)      line_bytes.push_back(pick_alnum());
        else if (r >= 4) line_bytes.push_back(pick_sep());
        add_keyword();
        r = $urandom_range(0, 9);
        if (r < 5)       line_bytes.push_back(pick_right_edge());
        else if (r < 7)  line_bytes.push_back(pick_sep());
        else if (r < 8)  line_bytes.push_back(pick_alnum());
      end
    end else if (mode < 72) begin
      // caret underline, broken at times
      repeat ($urandom_range(0, 3)) line_bytes.push_back(" ");
      line_bytes.push_back($urandom_range(0, 7) == 0 ? 8'("~") : 8'("^"));
      repeat ($urandom_range(0, 4)) line_bytes.push_back($urandom_range(0, 1) ? "^" : "~");
      repeat ($urandom_range(0, 2)) line_bytes.push_back(" ");
      if ($urandom_range(0, 3) == 0)
        line_bytes.insert($urandom_range(0, line_bytes.size()), pick_sep());
    end else if (mode < 87) begin
      add_noise(0, 14);
    end else begin
      add_noise(1, 5);
      add_keyword();
      add_noise(0, 3);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_empty_lines();
    send_line();
    send_line();
  endtask

  task automatic test_whole_words();
    send_text("error");
    send_text("[WARN]");
    send_text("x:Note)");
    send_text("errors");
    send_text("1Info:");
    send_text("Hint");
  endtask

  task automatic test_substrings();
    send_text("xPANICKED9");
    send_text("Deprecated");
    send_text("a: error:b");
    send_text("error[E0");
  endtask

  task automatic test_precedence();
    send_text("note warn");
    send_text("info FATAL");
  endtask

  task automatic test_underlines();
    send_text("^~~");
    send_text(" ^");
    send_text("^");
    send_text("^x~");
  endtask

  // Zero and high bytes, then a line long enough to saturate the byte count
  task automatic test_byte_extremes();
    line_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    append_text("eRr!");
    send_line();
    send_text("0123456789abcdef WARNING");
  endtask

  task automatic test_random_lines();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      no_gaps = (items_sent - start >= 200) && (items_sent - start < 330);
      build_random_line();
      send_line();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_lines();
    test_whole_words();
    test_substrings();
    test_precedence();
    test_underlines();
    test_byte_extremes();
    test_random_lines();

    s_axis_tvalid <= 1'b0;
    // let the last accepted terminator reach the model first
    @(posedge clk_i);
    while (pending_classes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("log_line_severity_classifier_core verification clean");
    end else begin
      $display("log_line_severity_classifier_core verification failed");
    end
    $finish;
  end

endmodule
